>>> rtl/jfd_pkg.sv
// Shared types, constants and helper functions of the joystick frame decoder.
// Used by the front end, the back end and the top level; depends on nothing.
package jfd_pkg;

   // Frame geometry defaults and storage sizes.
   localparam int FRAME_LEN_DEF  = 31;
   localparam int DATA_START_DEF = 5;
   localparam int STORE_DEPTH    = 64;
   localparam int STORE_AW       = 6;
   localparam int RAM_AW         = STORE_AW + 1;
   localparam int DESC_DEPTH     = 2;
   localparam int RESULT_DEPTH   = 4;

   // Byte counter saturates so that over-long chunks stay too long.
   localparam int                 COUNT_W       = 7;
   localparam logic [COUNT_W-1:0] COUNT_MAX     = 7'd127;
   localparam int                 CRC_LAG_BYTES = 3;
   localparam logic [15:0]        CRC_POLY      = 16'h1021;

   localparam int CSR_DATA_W = 15;

   typedef enum logic [2:0] {
      STAT_OK        = 3'd0,
      STAT_SHORT     = 3'd1,
      STAT_BAD_START = 3'd2,
      STAT_BAD_END   = 3'd3,
      STAT_BAD_CRC   = 3'd4,
      STAT_LONG      = 3'd5
   } frame_status_type;

   typedef enum logic [1:0] {
      CSR_START_CHAR = 2'd0,
      CSR_END_CHAR   = 2'd1,
      CSR_BIG_DZ     = 2'd2,
      CSR_SMALL_DZ   = 2'd3
   } csr_index_type;

   typedef enum logic [3:0] {
      FLD_AXIS0    = 4'd0,
      FLD_AXIS1    = 4'd1,
      FLD_AXIS2    = 4'd2,
      FLD_AXIS3    = 4'd3,
      FLD_AXIS4    = 4'd4,
      FLD_AXIS5    = 4'd5,
      FLD_AXIS6    = 4'd6,
      FLD_POT0     = 4'd7,
      FLD_POT1     = 4'd8,
      FLD_ROTARY_B = 4'd9,
      FLD_ROTARY_A = 4'd10,
      FLD_ENC0     = 4'd11,
      FLD_ENC1     = 4'd12,
      FLD_BUTTON   = 4'd13,
      FLD_TOGGLES  = 4'd14,
      FLD_BUTTONS  = 4'd15
   } field_id_type;

   typedef enum logic [2:0] {
      B_IDLE,
      B_ERROR,
      B_FIRST,
      B_HIGH,
      B_EMIT
   } back_state_type;

   // One finished chunk handed from the front end to the back end.
   typedef struct packed {
      frame_status_type status;
      logic             bank;
   } desc_type;

   // One result transaction.
   typedef struct packed {
      frame_status_type   status;
      field_id_type       field_id;
      logic signed [16:0] value;
      logic               last;
   } result_type;

   // Back end hands a store bank back to the front end.
   typedef struct packed {
      logic valid;
      logic bank;
   } release_type;

   // One byte of CRC-16/XMODEM, MSB first.
   function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {b, 8'h00};
      for (int k = 0; k < 8; k++) begin
         c = c[15] ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
      end
      return c;
   endfunction

   // Offset of a field's low byte from the start of the payload.
   function automatic logic [4:0] field_offset(input field_id_type f);
      logic [4:0] off;
      case (f)
         FLD_ROTARY_B, FLD_ROTARY_A: off = 5'd18;
         FLD_ENC0:                   off = 5'd19;
         FLD_ENC1:                   off = 5'd20;
         FLD_BUTTON, FLD_TOGGLES:    off = 5'd21;
         FLD_BUTTONS:                off = 5'd22;
         default:                    off = {f[3:0], 1'b0};
      endcase
      return off;
   endfunction

   // Axes and pots are two bytes wide; all other fields use one byte.
   function automatic logic field_wide(input field_id_type f);
      return (f <= FLD_POT1);
   endfunction

endpackage

>>> rtl/jfd_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Holds the received frame bytes; no dependencies.
module jfd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 128
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Read port; data holds while no read is issued.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/jfd_fifo.sv
// Small register-based first-in first-out queue of generic width.
// Used for chunk descriptors and for results; no dependencies.
module jfd_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] din,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] dout,
   output logic             empty
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]    count_ff, count_in;
   logic             do_push, do_pop;

   assign full    = (count_ff == CW'(DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push & ~full;
   assign do_pop  = pop & ~empty;
   assign dout    = mem_ff[rd_ptr_ff];

   // Pointer and occupancy updates.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage.
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= din;
      end
   end

endmodule

>>> rtl/jfd_front.sv
// Front end: accepts bytes, runs the CRC, writes the frame store and
// classifies each chunk. Depends on jfd_pkg.
module jfd_front
   import jfd_pkg::*;
#(
   parameter int FRAME_LEN = FRAME_LEN_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   output logic              full,
   input  logic [7:0]        data_byte,
   input  logic              chunk_end,
   input  logic [7:0]        start_char,
   input  logic [7:0]        end_char,
   output logic              desc_push,
   output desc_type          desc,
   input  logic              desc_full,
   input  release_type       bank_release,
   output logic              wr_en,
   output logic [RAM_AW-1:0] wr_addr,
   output logic [7:0]        wr_data
);

   logic [COUNT_W-1:0] count_ff, count_in;
   logic [15:0]        crc_ff, crc_in;
   logic [23:0]        lag_ff, lag_in;
   logic [7:0]         first_ff;
   logic               wr_bank_ff, wr_bank_in;
   logic [1:0]         busy_ff, busy_in;
   logic               accept;
   logic [15:0]        crc_step;
   logic [COUNT_W-1:0] count_inc;
   frame_status_type   status;

   // A byte is taken only while the bank it would land in is free.
   assign full   = busy_ff[wr_bank_ff] | desc_full;
   assign accept = push & ~full;

   // The CRC trails the input by three bytes.
   always_comb begin
      crc_step  = (count_ff >= COUNT_W'(CRC_LAG_BYTES)) ? crc_byte(crc_ff, lag_ff[23:16])
                                                         : crc_ff;
      count_inc = (count_ff == COUNT_MAX) ? count_ff : count_ff + 1'b1;
   end

   // Chunk checks in priority order: length, start, end, CRC.
   always_comb begin
      if (count_inc < COUNT_W'(FRAME_LEN)) begin
         status = STAT_SHORT;
      end else if (count_inc > COUNT_W'(FRAME_LEN)) begin
         status = STAT_LONG;
      end else if (first_ff != start_char) begin
         status = STAT_BAD_START;
      end else if (data_byte != end_char) begin
         status = STAT_BAD_END;
      end else if ({crc_step[7:0], crc_step[15:8]} != lag_ff[15:0]) begin
         status = STAT_BAD_CRC;
      end else begin
         status = STAT_OK;
      end
   end

   // Frame store write and descriptor hand-off.
   always_comb begin
      wr_en       = accept && (count_ff < COUNT_W'(FRAME_LEN));
      wr_addr     = {wr_bank_ff, count_ff[STORE_AW-1:0]};
      wr_data     = data_byte;
      desc_push   = accept & chunk_end;
      desc.status = status;
      desc.bank   = wr_bank_ff;
   end

   // Per-chunk state and bank ownership.
   always_comb begin
      count_in   = count_ff;
      crc_in     = crc_ff;
      lag_in     = lag_ff;
      wr_bank_in = wr_bank_ff;
      busy_in    = busy_ff;
      if (accept) begin
         if (chunk_end) begin
            count_in = '0;
            crc_in   = '0;
            lag_in   = '0;
         end else begin
            count_in = count_inc;
            crc_in   = crc_step;
            lag_in   = {lag_ff[15:0], data_byte};
         end
      end
      if (bank_release.valid) begin
         busy_in[bank_release.bank] = 1'b0;
      end
      if (desc_push && status == STAT_OK) begin
         busy_in[wr_bank_ff] = 1'b1;
         wr_bank_in          = ~wr_bank_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff   <= '0;
         crc_ff     <= '0;
         lag_ff     <= '0;
         wr_bank_ff <= 1'b0;
         busy_ff    <= '0;
      end else begin
         count_ff   <= count_in;
         crc_ff     <= crc_in;
         lag_ff     <= lag_in;
         wr_bank_ff <= wr_bank_in;
         busy_ff    <= busy_in;
      end
   end

   // The first byte of the chunk is kept for the start check.
   always_ff @(posedge clock) begin
      if (accept && count_ff == '0) begin
         first_ff <= data_byte;
      end
   end

   // A chunk end always leaves clean per-chunk state.
   assert property (@(posedge clock) disable iff (reset)
      (accept && chunk_end) |=> (count_ff == '0 && crc_ff == '0 && lag_ff == '0))
      else $error("per-chunk state not cleared after chunk end");

   // Only a bank that was handed out can come back.
   assert property (@(posedge clock) disable iff (reset)
      bank_release.valid |-> busy_ff[bank_release.bank])
      else $error("release of a bank that is not busy");

endmodule

>>> rtl/jfd_back.sv
// Back end: takes chunk descriptors, reads the stored frame and emits the
// status result or the sixteen decoded fields. Depends on jfd_pkg.
module jfd_back
   import jfd_pkg::*;
#(
   parameter int DATA_START = DATA_START_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  desc_empty,
   output logic                  desc_pop,
   input  desc_type              desc,
   input  logic [CSR_DATA_W-1:0] big_dz,
   input  logic [CSR_DATA_W-1:0] small_dz,
   output logic                  rd_en,
   output logic [RAM_AW-1:0]     rd_addr,
   input  logic [7:0]            rd_data,
   output logic                  out_push,
   input  logic                  out_full,
   output result_type            result,
   output release_type           bank_release
);

   back_state_type     state_ff, state_in;
   field_id_type       field_ff, field_in;
   field_id_type       field_next;
   field_id_type       rd_field;
   logic               rd_hi;
   logic               bank_ff, bank_in;
   frame_status_type   status_ff, status_in;
   logic [7:0]         lo_ff, lo_in;
   logic               last_field;
   logic [CSR_DATA_W-1:0] dz;
   logic signed [17:0] v, d, v_adj;
   logic signed [16:0] value;

   assign field_next = field_id_type'(field_ff + 4'd1);
   assign last_field = (field_ff == FLD_BUTTONS);

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         B_IDLE: begin
            if (!desc_empty) begin
               state_in = (desc.status == STAT_OK) ? B_FIRST : B_ERROR;
            end
         end
         B_ERROR: begin
            if (!out_full) begin
               state_in = B_IDLE;
            end
         end
         B_FIRST: begin
            state_in = B_HIGH;
         end
         B_HIGH: begin
            state_in = B_EMIT;
         end
         B_EMIT: begin
            if (!out_full) begin
               if (last_field) begin
                  state_in = B_IDLE;
               end else if (field_wide(field_next)) begin
                  state_in = B_HIGH;
               end else begin
                  state_in = B_EMIT;
               end
            end
         end
         default: begin
            state_in = B_IDLE;
         end
      endcase
   end

   // Decode of the current field from the bytes read.
   always_comb begin
      dz    = (field_ff <= FLD_AXIS2) ? big_dz : small_dz;
      v     = {{2{rd_data[7]}}, rd_data, lo_ff};
      d     = {3'b000, dz};
      v_adj = '0;
      if (v >= d) begin
         v_adj = v - d;
      end else if (v <= -d) begin
         v_adj = v + d;
      end
      case (field_ff)
         FLD_AXIS0, FLD_AXIS1, FLD_AXIS2, FLD_AXIS3,
         FLD_AXIS4, FLD_AXIS5, FLD_AXIS6: value = v_adj[16:0];
         FLD_POT0, FLD_POT1:              value = {1'b0, rd_data, lo_ff};
         FLD_ROTARY_B:                    value = {13'd0, rd_data[7:4]};
         FLD_ROTARY_A:                    value = {13'd0, rd_data[3:0]};
         FLD_ENC0, FLD_ENC1:              value = {{9{rd_data[7]}}, rd_data};
         FLD_BUTTON:                      value = {16'd0, rd_data[6]};
         FLD_TOGGLES:                     value = {12'd0, rd_data[4:0]};
         FLD_BUTTONS:                     value = {11'd0, rd_data[5:0]};
         default:                         value = '0;
      endcase
   end

   // Outputs: descriptor pop, store reads, result push and bank release.
   always_comb begin
      desc_pop           = 1'b0;
      rd_en              = 1'b0;
      rd_field           = field_ff;
      rd_hi              = 1'b0;
      out_push           = 1'b0;
      result.status      = STAT_OK;
      result.field_id    = field_ff;
      result.value       = value;
      result.last        = last_field;
      bank_release.valid = 1'b0;
      bank_release.bank  = bank_ff;
      case (state_ff)
         B_IDLE: begin
            desc_pop = !desc_empty;
         end
         B_ERROR: begin
            out_push        = !out_full;
            result.status   = status_ff;
            result.field_id = FLD_AXIS0;
            result.value    = '0;
            result.last     = 1'b1;
         end
         B_FIRST: begin
            rd_en = 1'b1;
         end
         B_HIGH: begin
            rd_en = 1'b1;
            rd_hi = 1'b1;
         end
         B_EMIT: begin
            out_push           = !out_full;
            rd_en              = !out_full && !last_field;
            rd_field           = field_next;
            bank_release.valid = !out_full && last_field;
         end
         default: begin
            desc_pop = 1'b0;
         end
      endcase
      rd_addr = {bank_ff, STORE_AW'(DATA_START) + STORE_AW'(field_offset(rd_field))
                          + STORE_AW'(rd_hi)};
   end

   // Field counter, bank, status and low byte holding.
   always_comb begin
      field_in  = field_ff;
      bank_in   = bank_ff;
      status_in = status_ff;
      lo_in     = lo_ff;
      if (state_ff == B_IDLE && !desc_empty) begin
         field_in  = FLD_AXIS0;
         bank_in   = desc.bank;
         status_in = desc.status;
      end
      if (state_ff == B_HIGH) begin
         lo_in = rd_data;
      end
      if (state_ff == B_EMIT && !out_full && !last_field) begin
         field_in = field_next;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= B_IDLE;
         field_ff <= FLD_AXIS0;
      end else begin
         state_ff <= state_in;
         field_ff <= field_in;
      end
   end

   always_ff @(posedge clock) begin
      bank_ff   <= bank_in;
      status_ff <= status_in;
      lo_ff     <= lo_in;
   end

   // The final result of a chunk returns the sequencer to idle.
   assert property (@(posedge clock) disable iff (reset)
      (out_push && result.last) |=> (state_ff == B_IDLE))
      else $error("sequencer did not return to idle after last result");

   // After a field is emitted mid-frame the next field is being read.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == B_EMIT && out_push && !last_field)
      |=> (state_ff == B_HIGH || state_ff == B_EMIT))
      else $error("sequencer left the frame before its last field");

endmodule

>>> rtl/joystick_frame_decoder_core.sv
// Joystick frame decoder top level: configuration registers, frame store,
// front end, descriptor queue, back end and result queue. Depends on jfd_pkg.
// Throughput: one byte per cycle while the back end keeps up. A good frame drains faster
// than it arrives, using two alternating store banks; each rejected chunk passes the back
// end through its idle and error states, so one-byte chunks are paced by the back end.
// A status result passes the descriptor queue, the back end's idle and error states and
// the result queue; a first field passes the idle, first, high and emit states instead.
// Reset is synchronous; frame store contents stay undefined, no clearing pass.
module joystick_frame_decoder_core
   import jfd_pkg::*;
#(
   parameter int FRAME_LEN  = FRAME_LEN_DEF,
   parameter int DATA_START = DATA_START_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   output logic                  full,
   input  logic [7:0]            req_data_byte,
   input  logic                  req_chunk_end,
   output logic                  empty,
   input  logic                  pop,
   output logic [2:0]            rsp_frame_status,
   output logic [3:0]            rsp_field_id,
   output logic signed [16:0]    rsp_field_value,
   output logic                  rsp_last_of_frame,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [1:0]            csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   logic [7:0]            start_char_ff, end_char_ff;
   logic [CSR_DATA_W-1:0] big_dz_ff, small_dz_ff;

   logic                  desc_push, desc_full, desc_pop, desc_empty;
   desc_type              desc_wr, desc_rd;
   logic [$bits(desc_type)-1:0] desc_bits;
   release_type           bank_release;
   logic                  wr_en, rd_en;
   logic [RAM_AW-1:0]     wr_addr, rd_addr;
   logic [7:0]            wr_data, rd_data;
   logic                  out_push, out_full;
   result_type            result_wr, result_rd;
   logic [$bits(result_type)-1:0] result_bits;

   // Configuration transactions are always taken.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         start_char_ff <= '0;
         end_char_ff   <= '0;
         big_dz_ff     <= '0;
         small_dz_ff   <= '0;
      end else if (csr_valid) begin
         case (csr_index_type'(csr_index))
            CSR_START_CHAR: start_char_ff <= csr_wdata[7:0];
            CSR_END_CHAR:   end_char_ff   <= csr_wdata[7:0];
            CSR_BIG_DZ:     big_dz_ff     <= csr_wdata;
            CSR_SMALL_DZ:   small_dz_ff   <= csr_wdata;
            default:        start_char_ff <= start_char_ff;
         endcase
      end
   end

   // Frame store: two banks so one frame can decode while the next arrives.
   jfd_ram #(
      .WIDTH (8),
      .DEPTH (2 * STORE_DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   jfd_front #(
      .FRAME_LEN (FRAME_LEN)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .push         (push),
      .full         (full),
      .data_byte    (req_data_byte),
      .chunk_end    (req_chunk_end),
      .start_char   (start_char_ff),
      .end_char     (end_char_ff),
      .desc_push    (desc_push),
      .desc         (desc_wr),
      .desc_full    (desc_full),
      .bank_release (bank_release),
      .wr_en        (wr_en),
      .wr_addr      (wr_addr),
      .wr_data      (wr_data)
   );

   // Queue of classified chunks between front and back.
   jfd_fifo #(
      .WIDTH ($bits(desc_type)),
      .DEPTH (DESC_DEPTH)
   ) u_desc_q (
      .clock (clock),
      .reset (reset),
      .push  (desc_push),
      .din   (desc_wr),
      .full  (desc_full),
      .pop   (desc_pop),
      .dout  (desc_bits),
      .empty (desc_empty)
   );

   assign desc_rd = desc_type'(desc_bits);

   jfd_back #(
      .DATA_START (DATA_START)
   ) u_back (
      .clock        (clock),
      .reset        (reset),
      .desc_empty   (desc_empty),
      .desc_pop     (desc_pop),
      .desc         (desc_rd),
      .big_dz       (big_dz_ff),
      .small_dz     (small_dz_ff),
      .rd_en        (rd_en),
      .rd_addr      (rd_addr),
      .rd_data      (rd_data),
      .out_push     (out_push),
      .out_full     (out_full),
      .result       (result_wr),
      .bank_release (bank_release)
   );

   // Result queue facing the consumer.
   jfd_fifo #(
      .WIDTH ($bits(result_type)),
      .DEPTH (RESULT_DEPTH)
   ) u_result_q (
      .clock (clock),
      .reset (reset),
      .push  (out_push),
      .din   (result_wr),
      .full  (out_full),
      .pop   (pop),
      .dout  (result_bits),
      .empty (empty)
   );

   assign result_rd         = result_type'(result_bits);
   assign rsp_frame_status  = result_rd.status;
   assign rsp_field_id      = result_rd.field_id;
   assign rsp_field_value   = result_rd.value;
   assign rsp_last_of_frame = result_rd.last;

endmodule

>>> tb/tb_joystick_frame_decoder_core.sv
// Self-checking testbench for joystick_frame_decoder_core: serial bytes in, decoded fields out.
// Depends on jfd_pkg and the core RTL; stimulus and expected fields are generated here.
module tb_joystick_frame_decoder_core;
   import jfd_pkg::*;

   localparam int PAY_LEN = 23;

   typedef struct packed {
      logic [7:0] data;
      logic       last;
   } serial_byte_type;

   typedef enum int {
      CH_GOOD,
      CH_BAD_START,
      CH_BAD_END,
      CH_BAD_CRC,
      CH_SHORT,
      CH_LONG,
      CH_NOISE
   } chunk_kind_type;

   // Clock and reset.
   logic clock = 1'b0;
   logic reset = 1'b1;

   always #6 clock = ~clock;

   // Block ports.
   logic                  push = 1'b0;
   logic                  full;
   logic [7:0]            req_data_byte = '0;
   logic                  req_chunk_end = 1'b0;
   logic                  empty;
   logic                  pop = 1'b0;
   logic [2:0]            rsp_frame_status;
   logic [3:0]            rsp_field_id;
   logic signed [16:0]    rsp_field_value;
   logic                  rsp_last_of_frame;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [1:0]            csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   joystick_frame_decoder_core u_dut (
      .clock             (clock),
      .reset             (reset),
      .push              (push),
      .full              (full),
      .req_data_byte     (req_data_byte),
      .req_chunk_end     (req_chunk_end),
      .empty             (empty),
      .pop               (pop),
      .rsp_frame_status  (rsp_frame_status),
      .rsp_field_id      (rsp_field_id),
      .rsp_field_value   (rsp_field_value),
      .rsp_last_of_frame (rsp_last_of_frame),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata)
   );

   // Decoder mirror: register copies and per-chunk state.
   logic [7:0]  mir_start_char = '0;
   logic [7:0]  mir_end_char   = '0;
   logic [14:0] mir_big_dz     = '0;
   logic [14:0] mir_small_dz   = '0;
   logic [7:0]  seen_bytes [FRAME_LEN_DEF];
   logic [6:0]  seen_count = '0;
   logic [15:0] sum_crc    = '0;
   logic [23:0] crc_delay  = '0;

   // Stimulus plan and bookkeeping.
   serial_byte_type send_q [$];
   result_type      decoded_q [$];
   logic [7:0]      chunk_bytes [$];
   logic [7:0]      pay [PAY_LEN];
   logic [7:0]      cfg_start, cfg_end;
   logic [14:0]     cfg_big_dz, cfg_small_dz;
   bit              idle_on = 1'b1;
   int              push_hold, pop_hold;
   int              bytes_queued, bytes_taken;
   int              results_checked, chunks_good, chunks_rejected, fault_count;

   // One byte of CRC-16/XMODEM, fed one bit at a time.
   function automatic logic [15:0] crc_xmodem_step(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      logic        fb;
      c = crc;
      for (int i = 7; i >= 0; i--) begin
         fb = c[15] ^ b[i];
         c  = {c[14:0], 1'b0} ^ (fb ? CRC_POLY : 16'h0000);
      end
      return c;
   endfunction

   // Pull a signed stick reading towards zero by the dead zone.
   function automatic logic signed [16:0] shrink_axis(input logic [15:0] raw,
                                                      input logic [14:0] dz);
      int v, d;
      v = $signed(raw);
      d = dz;
      if (v > -d && v < d) v = 0;
      else if (v >= d) v = v - d;
      else v = v + d;
      return v[16:0];
   endfunction

   // Decoded value of one field, read from the bytes of the finished frame.
   function automatic logic signed [16:0] field_value_of(input field_id_type f);
      logic [15:0] word;
      logic [7:0]  t;
      int          base;
      base = DATA_START_DEF;
      if (f <= FLD_POT1) begin
         word = {seen_bytes[base + 2 * int'(f) + 1], seen_bytes[base + 2 * int'(f)]};
         if (f <= FLD_AXIS6)
            return shrink_axis(word, (f <= FLD_AXIS2) ? mir_big_dz : mir_small_dz);
         return {1'b0, word};
      end
      case (f)
         FLD_ROTARY_B: begin
            t = seen_bytes[base + 18];
            return {13'd0, t[7:4]};
         end
         FLD_ROTARY_A: begin
            t = seen_bytes[base + 18];
            return {13'd0, t[3:0]};
         end
         FLD_ENC0: begin
            t = seen_bytes[base + 19];
            return {{9{t[7]}}, t};
         end
         FLD_ENC1: begin
            t = seen_bytes[base + 20];
            return {{9{t[7]}}, t};
         end
         FLD_BUTTON: begin
            t = seen_bytes[base + 21];
            return {16'd0, t[6]};
         end
         FLD_TOGGLES: begin
            t = seen_bytes[base + 21];
            return {12'd0, t[4:0]};
         end
         default: begin
            t = seen_bytes[base + 22];
            return {11'd0, t[5:0]};
         end
      endcase
   endfunction

   // Advance the mirror by one accepted byte and queue the fields it produces.
   task automatic decode_serial_byte(input logic [7:0] b, input logic ce);
      logic [6:0]       n;
      logic [15:0]      crc;
      logic [15:0]      rx;
      frame_status_type st;
      result_type       r;
      if (seen_count >= 7'd3) sum_crc = crc_xmodem_step(sum_crc, crc_delay[23:16]);
      crc_delay = {crc_delay[15:0], b};
      if (seen_count < FRAME_LEN_DEF) seen_bytes[seen_count] = b;
      if (seen_count != COUNT_MAX) seen_count = seen_count + 7'd1;
      if (ce) begin
         n          = seen_count;
         crc        = sum_crc;
         rx         = crc_delay[23:8];
         seen_count = '0;
         sum_crc    = '0;
         crc_delay  = '0;
         if (n < FRAME_LEN_DEF) st = STAT_SHORT;
         else if (n > FRAME_LEN_DEF) st = STAT_LONG;
         else if (seen_bytes[0] != mir_start_char) st = STAT_BAD_START;
         else if (b != mir_end_char) st = STAT_BAD_END;
         else if ({crc[7:0], crc[15:8]} != rx) st = STAT_BAD_CRC;
         else st = STAT_OK;
         if (st != STAT_OK) begin
            r.status   = st;
            r.field_id = FLD_AXIS0;
            r.value    = '0;
            r.last     = 1'b1;
            decoded_q.push_back(r);
            chunks_rejected++;
         end else begin
            for (int k = 0; k < 16; k++) begin
               r.status   = STAT_OK;
               r.field_id = field_id_type'(k);
               r.value    = field_value_of(field_id_type'(k));
               r.last     = (k == 15);
               decoded_q.push_back(r);
            end
            chunks_good++;
         end
      end
   endtask

   // Compare one result transaction with the oldest expected field.
   task automatic check_result();
      result_type w;
      results_checked++;
      if (decoded_q.size() == 0) begin
         fault_count++;
         if (fault_count <= 10)
            $display("Unexpected result at %0t: status %0d field %0d value %0d last %0b",
                     $time, rsp_frame_status, rsp_field_id, rsp_field_value,
                     rsp_last_of_frame);
      end else begin
         w = decoded_q.pop_front();
         if (rsp_frame_status != w.status || rsp_field_id != w.field_id ||
             rsp_field_value != w.value || rsp_last_of_frame != w.last) begin
            fault_count++;
            if (fault_count <= 10)
               $display("Mismatch at %0t: want %0d/%0d/%0d/%0b, got %0d/%0d/%0d/%0b %s",
                        $time, w.status, w.field_id, w.value, w.last, rsp_frame_status,
                        rsp_field_id, rsp_field_value, rsp_last_of_frame,
                        "(status/field/value/last)");
         end
      end
   endtask

   // Input driver: presents queued bytes, with random idle bursts.
   always @(posedge clock) begin
      serial_byte_type nxt;
      if (reset) begin
         push          <= 1'b0;
         req_data_byte <= '0;
         req_chunk_end <= 1'b0;
         push_hold = 0;
      end else begin
         if (push && !full) begin
            decode_serial_byte(req_data_byte, req_chunk_end);
            bytes_taken++;
         end
         if (!push || !full) begin
            if (push_hold > 0) begin
               push_hold--;
               push <= 1'b0;
            end else if (idle_on && $urandom_range(0, 11) == 0) begin
               push_hold = $urandom_range(0, 17);
               push <= 1'b0;
            end else if (send_q.size() != 0) begin
               nxt = send_q.pop_front();
               push          <= 1'b1;
               req_data_byte <= nxt.data;
               req_chunk_end <= nxt.last;
            end else begin
               push <= 1'b0;
            end
         end
      end
   end

   // Result monitor: pops results, with random stall bursts.
   always @(posedge clock) begin
      if (reset) begin
         pop <= 1'b0;
         pop_hold = 0;
      end else begin
         if (pop && !empty) check_result();
         if (pop_hold > 0) begin
            pop_hold--;
            pop <= 1'b0;
         end else if (idle_on && $urandom_range(0, 9) == 0) begin
            pop_hold = $urandom_range(0, 17);
            pop <= 1'b0;
         end else begin
            pop <= 1'b1;
         end
      end
   end

   // Register mirror follows every accepted write transaction.
   always @(posedge clock) begin
      if (!reset && csr_valid && csr_ready) begin
         case (csr_index)
            CSR_START_CHAR: mir_start_char = csr_wdata[7:0];
            CSR_END_CHAR:   mir_end_char   = csr_wdata[7:0];
            CSR_BIG_DZ:     mir_big_dz     = csr_wdata;
            CSR_SMALL_DZ:   mir_small_dz   = csr_wdata;
            default: ;
         endcase
      end
   end

   task automatic write_reg(input csr_index_type idx, input logic [CSR_DATA_W-1:0] val);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic apply_settings(input logic [7:0] sc, input logic [7:0] ec,
                                 input logic [14:0] bdz, input logic [14:0] sdz);
      cfg_start    = sc;
      cfg_end      = ec;
      cfg_big_dz   = bdz;
      cfg_small_dz = sdz;
      write_reg(CSR_START_CHAR, {7'd0, sc});
      write_reg(CSR_END_CHAR, {7'd0, ec});
      write_reg(CSR_BIG_DZ, bdz);
      write_reg(CSR_SMALL_DZ, sdz);
   endtask

   // Wait until every byte is taken and every field has come back.
   task automatic wait_drained();
      @(posedge clock);
      while (bytes_taken != bytes_queued || decoded_q.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic set_axis(input int k, input logic [15:0] v);
      pay[2 * k]     = v[7:0];
      pay[2 * k + 1] = v[15:8];
   endtask

   // Stick readings cluster around the dead zone edges and the extremes.
   function automatic logic [15:0] axis_near_deadzone(input logic [14:0] dz);
      logic [15:0] d;
      d = {1'b0, dz};
      case ($urandom_range(0, 7))
         0: return d;
         1: return d - 16'd1;
         2: return d + 16'd1;
         3: return 16'h0000 - d;
         4: return 16'h0001 - d;
         5: return 16'hFFFF - d;
         6: return $urandom_range(0, 1) ? 16'h8000 : 16'h7FFF;
         default: return 16'($urandom);
      endcase
   endfunction

   task automatic randomize_payload();
      for (int i = 0; i < PAY_LEN; i++) pay[i] = 8'($urandom);
      for (int k = 0; k < 7; k++)
         set_axis(k, axis_near_deadzone(k < 3 ? cfg_big_dz : cfg_small_dz));
      for (int k = 7; k < 9; k++)
         if ($urandom_range(0, 3) == 0) set_axis(k, $urandom_range(0, 1) ? 16'hFFFF : 16'h0000);
   endtask

   // Well-formed frame around the current payload: start, header, payload, CRC, end.
   task automatic build_frame();
      logic [15:0] crc;
      chunk_bytes.delete();
      chunk_bytes.push_back(cfg_start);
      repeat (DATA_START_DEF - 1) chunk_bytes.push_back(8'($urandom));
      for (int i = 0; i < PAY_LEN; i++) chunk_bytes.push_back(pay[i]);
      crc = '0;
      foreach (chunk_bytes[i]) crc = crc_xmodem_step(crc, chunk_bytes[i]);
      chunk_bytes.push_back(crc[7:0]);
      chunk_bytes.push_back(crc[15:8]);
      chunk_bytes.push_back(cfg_end);
   endtask

   task automatic send_chunk();
      serial_byte_type sb;
      foreach (chunk_bytes[i]) begin
         sb.data = chunk_bytes[i];
         sb.last = (i == chunk_bytes.size() - 1);
         send_q.push_back(sb);
      end
      bytes_queued += chunk_bytes.size();
   endtask

   task automatic queue_chunk(input chunk_kind_type kind);
      int n, pos;
      randomize_payload();
      build_frame();
      case (kind)
         CH_BAD_START: chunk_bytes[0] = chunk_bytes[0] ^ 8'($urandom_range(1, 255));
         CH_BAD_END: begin
            pos = FRAME_LEN_DEF - 1;
            chunk_bytes[pos] = chunk_bytes[pos] ^ 8'($urandom_range(1, 255));
         end
         CH_BAD_CRC: begin
            // A single flipped bit in any byte after the start character, up to and including the CRC.
            pos = $urandom_range(1, FRAME_LEN_DEF - 2);
            chunk_bytes[pos] = chunk_bytes[pos] ^ (8'h01 << $urandom_range(0, 7));
         end
         CH_SHORT: begin
            n = $urandom_range(1, FRAME_LEN_DEF - 1);
            while (chunk_bytes.size() > n) void'(chunk_bytes.pop_back());
         end
         CH_LONG: repeat ($urandom_range(1, 8)) chunk_bytes.push_back(8'($urandom));
         CH_NOISE: begin
            chunk_bytes.delete();
            repeat ($urandom_range(1, 40)) chunk_bytes.push_back(8'($urandom));
         end
         default: ;
      endcase
      send_chunk();
   endtask

   // Test sequence.
   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // First setting, with the directed chunks.
      apply_settings(8'hA5, 8'h5A, 15'd1000, 15'd200);
      chunk_bytes.delete();
      chunk_bytes.push_back(8'hFF);
      send_chunk();

      // Axes at the extremes and on and around the dead zone edges, pots at both ends and flag bytes.
      randomize_payload();
      set_axis(0, 16'h8000);
      set_axis(1, 16'h7FFF);
      set_axis(2, {1'b0, cfg_big_dz} - 16'd1);
      set_axis(3, 16'h0000 - {1'b0, cfg_small_dz});
      set_axis(4, 16'h0000);
      set_axis(5, {1'b0, cfg_small_dz});
      set_axis(6, 16'h0001 - {1'b0, cfg_small_dz});
      set_axis(7, 16'hFFFF);
      set_axis(8, 16'h0000);
      pay[18] = 8'hA5;
      pay[19] = 8'h80;
      pay[20] = 8'h7F;
      pay[21] = 8'hBF;
      pay[22] = 8'hFF;
      build_frame();
      send_chunk();

      // One byte short of the frame length, then a corrupted CRC.
      randomize_payload();
      build_frame();
      void'(chunk_bytes.pop_back());
      send_chunk();
      queue_chunk(CH_BAD_CRC);

      // Long enough to saturate the byte counter.
      chunk_bytes.delete();
      chunk_bytes.push_back(cfg_start);
      repeat (127) chunk_bytes.push_back(8'($urandom));
      send_chunk();
      wait_drained();

      // No dead zone on the large axes, the widest one on the small axes.
      apply_settings(8'h00, 8'hFF, 15'd0, 15'd32767);
      queue_chunk(CH_GOOD);
      queue_chunk(CH_BAD_START);
      wait_drained();

      // Last setting swaps the extremes and runs with both sides at full rate.
      idle_on = 1'b0;
      apply_settings(8'hFF, 8'h00, 15'd32767, 15'd0);
      queue_chunk(CH_GOOD);
      queue_chunk(CH_BAD_END);
      wait_drained();

      $display("Checked %0d results from %0d bytes: %0d frames decoded, %0d chunks rejected.",
               results_checked, bytes_taken, chunks_good, chunks_rejected);
      $display("Three register settings were used, covering both dead zone extremes.");
      if (fault_count == 0 && decoded_q.size() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

   // Watchdog for a hung handshake.
   initial begin
      #6000000;
      $display("FAILURE");
      $finish;
   end

endmodule

>>> joystick_frame_decoder_core.f
rtl/jfd_pkg.sv
rtl/jfd_ram.sv
rtl/jfd_fifo.sv
rtl/jfd_front.sv
rtl/jfd_back.sv
rtl/joystick_frame_decoder_core.sv
tb/tb_joystick_frame_decoder_core.sv
